/* rtl/ehvr_pkg.sv */
// ----------------------------------------------------------------------------
// ehvr_pkg
// Shared types and constants for the hook table violation resolver.
// ----------------------------------------------------------------------------
package ehvr_pkg;

    localparam int ADDR_W     = 64;
    localparam int PAGE_W     = 52;
    localparam int FRAME_W    = 40;
    localparam int PAGE_SHIFT = 12;

    // request modes
    localparam logic [1:0] MODE_ADD  = 2'd0;
    localparam logic [1:0] MODE_DEL  = 2'd1;
    localparam logic [1:0] MODE_VIOL = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOMATCH = 2'd2;
    localparam logic [1:0] ST_NOFAIL  = 2'd3;

    typedef struct packed {
        logic [1:0]        mode;
        logic [ADDR_W-1:0] target_address;
        logic [PAGE_W-1:0] rw_page_address;
        logic [PAGE_W-1:0] exec_page_address;
        logic              did_read;
        logic              did_write;
        logic              did_execute;
        logic              was_readable;
        logic              was_writable;
        logic              was_executable;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic               grant_read;
        logic               grant_write;
        logic               grant_execute;
        logic [FRAME_W-1:0] new_frame;
        logic [FRAME_W-1:0] patched_entry_frame;
    } t_out_item;

    typedef struct packed {
        logic [ADDR_W-1:0] hook;
        logic [PAGE_W-1:0] rw_page;
        logic [PAGE_W-1:0] exec_page;
    } t_entry;

    // controller -> datapath
    typedef struct packed {
        logic load;    // latch request, clear search state
        logic rd;      // read table entry at index
        logic cmp;     // compare entry read in previous cycle
        logic commit;  // update table, load output register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

/* rtl/ehvr_if.sv */
// ----------------------------------------------------------------------------
// ehvr_in_if / ehvr_out_if
// Valid/ready channels carrying request and result transactions.
// ----------------------------------------------------------------------------
interface ehvr_in_if;
    import ehvr_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ehvr_out_if;
    import ehvr_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/ehvr_ctrl.sv */
// ----------------------------------------------------------------------------
// ehvr_ctrl
// Sequencer: accept, scan table one entry per cycle, drain, commit.
// ----------------------------------------------------------------------------
module ehvr_ctrl #(
    parameter int TABLE_ENTRIES = 16,
    parameter int IDX_W         = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ehvr_pkg::t_dp_stat i_stat,
    output ehvr_pkg::t_dp_cmd  o_cmd,
    output logic [IDX_W-1:0]  o_rd_idx
);
    import ehvr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_COMMIT
    } t_state;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_cmp, n_cmp;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_cmp   = 1'b0;
        case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (i_in_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_cmp = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_cmp   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_cmp   <= n_cmp;
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_rd_idx     = r_idx;
    assign o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.rd     = (r_state == S_SCAN);
    assign o_cmd.cmp    = r_cmp;
    assign o_cmd.commit = (r_state == S_COMMIT) && i_stat.out_free;

endmodule

/* rtl/ehvr_dp.sv */
// ----------------------------------------------------------------------------
// ehvr_dp
// Entry memory, valid bits, search registers and result register.
// ----------------------------------------------------------------------------
module ehvr_dp #(
    parameter int TABLE_ENTRIES = 16,
    parameter int IDX_W         = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ehvr_pkg::t_dp_cmd   i_cmd,
    input  logic [IDX_W-1:0]    i_rd_idx,
    input  ehvr_pkg::t_in_item  i_in_data,
    output ehvr_pkg::t_dp_stat  o_stat,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ehvr_pkg::t_out_item o_out_data
);
    import ehvr_pkg::*;

    t_entry mem [TABLE_ENTRIES];

    logic [TABLE_ENTRIES-1:0] r_valid;
    t_in_item                 r_req;
    t_entry                   r_q;
    logic                     r_q_valid;
    logic [IDX_W-1:0]         r_q_idx;

    logic                     r_found;
    logic [IDX_W-1:0]         r_found_idx;
    logic [PAGE_W-1:0]        r_found_rw;
    logic [PAGE_W-1:0]        r_found_ex;
    logic                     r_free_found;
    logic [IDX_W-1:0]         r_free_idx;

    logic                     r_out_valid;
    t_out_item                r_out;

    logic                     hit;
    logic                     rw_fail;
    logic                     x_fail;
    logic                     we;
    logic                     w_valid;
    logic [IDX_W-1:0]         w_idx;
    t_entry                   w_data;
    t_out_item                n_out;

    // exact compare for add/delete, page compare for violations
    always_comb begin
        if (r_req.mode == MODE_VIOL) begin
            hit = r_q.hook[ADDR_W-1:PAGE_SHIFT]
                  == r_req.target_address[ADDR_W-1:PAGE_SHIFT];
        end else begin
            hit = r_q.hook == r_req.target_address;
        end
    end

    assign rw_fail = (r_req.did_read && !r_req.was_readable)
                  || (r_req.did_write && !r_req.was_writable);
    assign x_fail  = r_req.did_execute && !r_req.was_executable;

    always_comb begin
        we      = 1'b0;
        w_valid = 1'b0;
        w_idx   = r_free_idx;
        w_data  = '0;
        n_out   = '0;
        n_out.status = ST_NOMATCH;
        case (r_req.mode)
            MODE_ADD: begin
                if (r_found) begin
                    n_out.status = ST_OK;
                end else if (r_free_found) begin
                    n_out.status     = ST_OK;
                    we               = i_cmd.commit;
                    w_valid          = 1'b1;
                    w_data.hook      = r_req.target_address;
                    w_data.rw_page   = r_req.rw_page_address;
                    w_data.exec_page = r_req.exec_page_address;
                end else begin
                    n_out.status = ST_FULL;
                end
            end
            MODE_DEL: begin
                if (r_found) begin
                    n_out.status = ST_OK;
                    we           = i_cmd.commit;
                    w_idx        = r_found_idx;
                end
            end
            MODE_VIOL: begin
                if (r_found) begin
                    n_out.patched_entry_frame = r_found_ex[PAGE_W-1:PAGE_SHIFT];
                    if (rw_fail) begin
                        n_out.status      = ST_OK;
                        n_out.grant_read  = 1'b1;
                        n_out.grant_write = 1'b1;
                        n_out.new_frame   = r_found_rw[PAGE_W-1:PAGE_SHIFT];
                    end else if (x_fail) begin
                        n_out.status        = ST_OK;
                        n_out.grant_execute = 1'b1;
                        n_out.new_frame     = r_found_ex[PAGE_W-1:PAGE_SHIFT];
                    end else begin
                        n_out.status = ST_NOFAIL;
                    end
                end
            end
            default: begin
                n_out.status = ST_NOMATCH;
            end
        endcase
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[w_idx] <= w_data;
        end
        if (i_cmd.rd) begin
            r_q     <= mem[i_rd_idx];
            r_q_idx <= i_rd_idx;
        end
        if (i_cmd.load) begin
            r_req <= i_in_data;
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_q_valid    <= 1'b0;
            r_found      <= 1'b0;
            r_found_idx  <= '0;
            r_found_rw   <= '0;
            r_found_ex   <= '0;
            r_free_found <= 1'b0;
            r_free_idx   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (we) begin
                r_valid[w_idx] <= w_valid;
            end
            if (i_cmd.rd) begin
                r_q_valid <= r_valid[i_rd_idx];
            end
            if (i_cmd.load) begin
                r_found      <= 1'b0;
                r_free_found <= 1'b0;
            end else if (i_cmd.cmp) begin
                if (r_q_valid && hit && !r_found) begin
                    r_found     <= 1'b1;
                    r_found_idx <= r_q_idx;
                    r_found_rw  <= r_q.rw_page;
                    r_found_ex  <= r_q.exec_page;
                end
                if (!r_q_valid && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_q_idx;
                end
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;

endmodule

/* rtl/ept_hook_table_violation_resolver_core.sv */
// ----------------------------------------------------------------------------
// ept_hook_table_violation_resolver_core
// Page-swap hook table with add, delete and access-violation resolve.
// ----------------------------------------------------------------------------
// Each request transaction on i_in yields exactly one result transaction on
// o_out. The table holds TABLE_ENTRIES entries in a memory with one write
// port and one registered read port, scanned one entry per cycle: a request
// is accepted, each entry is read in turn, the last read is compared, and
// the result is committed. Requests are handled one at a time; i_in.ready is
// high only while the block is idle. A finished result sits in the output
// register until taken, and the next request is accepted while it waits;
// that next request then holds in its commit state until the earlier result
// is taken. Matching considers only valid entries, so a free slot never
// matches, not even address zero. Valid bits reset to zero at once; no
// clearing pass.
// ----------------------------------------------------------------------------
module ept_hook_table_violation_resolver_core #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ehvr_in_if.sink           i_in,
    ehvr_out_if.source        o_out
);
    import ehvr_pkg::*;

    // index width, at least one bit for a one-entry table
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    t_dp_cmd          cmd;
    t_dp_stat         stat;
    logic [IDX_W-1:0] rd_idx;

    // Controller: walks the scan index and sequences the datapath.
    ehvr_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_rd_idx   (rd_idx)
    );

    // Datapath: table memory, first-match search and result register.
    ehvr_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_rd_idx    (rd_idx),
        .i_in_data   (i_in.data),
        .o_stat      (stat),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_data  (o_out.data)
    );

`ifndef SYNTHESIS
    // one request at a time: no acceptance right after an acceptance
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("request accepted while previous one in flight");

    // commit only when the result register can take it
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> stat.out_free)
        else $error("commit would overwrite a pending result");

    // every commit shows a result in the next cycle
    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |=> o_out.valid)
        else $error("result missing after commit");

    // scan never runs while the block reports idle
    a_scan_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.rd |-> !i_in.ready)
        else $error("table scan while idle");
`endif

endmodule

/* test/tb_ept_hook_table_violation_resolver_core.sv */
// ----------------------------------------------------------------------------
// tb_ept_hook_table_violation_resolver_core
// Self-checking bench for the page-swap hook table and violation resolver.
// ----------------------------------------------------------------------------
// A short directed table comes first: empty-table lookups, address zero,
// duplicate add, read/write versus execute failure, no-failure lookups,
// non-exact delete, a full table. A random mix built around a small address
// pool follows, so adds, deletes and page hits really land on live entries.
// Every accepted request runs through a local copy of the table and the
// outcome is queued; each result transaction is checked against the head of
// that queue. The sender bursts with random gaps. The receiver stalls on its
// own pattern and holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_ept_hook_table_violation_resolver_core;
    import ehvr_pkg::*;

    localparam int         N_ENTRIES      = 16;
    localparam logic [1:0] MODE_UNDEF     = 2'd3;     // no operation assigned
    localparam int         RANDOM_ITEMS   = 1600;
    localparam int         POOL_SIZE      = 32;
    localparam int         HOLDOFF_AFTER  = 300;      // requests before holdoff
    localparam int         HOLDOFF_CYCLES = 500;
    localparam int         DRAIN_CYCLES   = 40;
    // covers each request, the idle gaps on the sender, the stall runs on the
    // receiver and the holdoff, taken several times over.
    localparam int         CYCLE_LIMIT    = 400000;

    typedef struct {
        t_in_item  req;
        bit        typed;   // want holds a hand-written result
        t_out_item want;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    ehvr_in_if  in_if ();
    ehvr_out_if out_if ();

    ept_hook_table_violation_resolver_core #(
        .TABLE_ENTRIES(N_ENTRIES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // local image of the hook table
    logic              hook_valid [N_ENTRIES];
    logic [ADDR_W-1:0] hook_addr  [N_ENTRIES];
    logic [PAGE_W-1:0] hook_rw    [N_ENTRIES];
    logic [PAGE_W-1:0] hook_exec  [N_ENTRIES];

    t_stim_row   stim_q [$];
    t_out_item   pending_results [$];
    logic [63:0] addr_pool [POOL_SIZE];

    // travels with the request on the channel, read at acceptance
    bit        drv_typed;
    t_out_item drv_want;

    bit stim_done;
    int err_count;
    int cycle_count;
    int reqs_accepted;
    int mode_seen   [4];
    int status_seen [4];

    // ------------------------------------------------------------------------
    // clock and watchdog
    // ------------------------------------------------------------------------
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [PAGE_W-1:0] rand52();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[PAGE_W-1:0];
    endfunction

    // flags: {did_read, did_write, did_execute,
    //         was_readable, was_writable, was_executable}
    function automatic t_in_item mk_req(logic [1:0] mode, logic [ADDR_W-1:0] addr,
                                        logic [PAGE_W-1:0] rw, logic [PAGE_W-1:0] ex,
                                        logic [5:0] flags);
        t_in_item r;
        r.mode              = mode;
        r.target_address    = addr;
        r.rw_page_address   = rw;
        r.exec_page_address = ex;
        {r.did_read, r.did_write, r.did_execute,
         r.was_readable, r.was_writable, r.was_executable} = flags;
        return r;
    endfunction

    function automatic t_out_item mk_res(logic [1:0] status, logic [2:0] grants,
                                         logic [FRAME_W-1:0] nf, logic [FRAME_W-1:0] pf);
        t_out_item r;
        r.status              = status;
        {r.grant_read, r.grant_write, r.grant_execute} = grants;
        r.new_frame           = nf;
        r.patched_entry_frame = pf;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // predictor: applies one request to the table image, returns its result
    // ------------------------------------------------------------------------
    function automatic t_out_item resolve_request(t_in_item req);
        t_out_item r;
        int        hit;
        logic      rw_fail;
        logic      x_fail;
        r        = '0;
        r.status = ST_NOMATCH;
        hit      = -1;
        case (req.mode)
            MODE_ADD: begin
                for (int i = 0; i < N_ENTRIES; i++)
                    if (hit < 0 && hook_valid[i] && hook_addr[i] == req.target_address)
                        hit = i;
                if (hit >= 0) begin
                    r.status = ST_OK;            // already hooked, table untouched
                end else begin
                    r.status = ST_FULL;
                    for (int i = 0; i < N_ENTRIES; i++) begin
                        if (r.status == ST_FULL && !hook_valid[i]) begin
                            hook_valid[i] = 1'b1;
                            hook_addr[i]  = req.target_address;
                            hook_rw[i]    = req.rw_page_address;
                            hook_exec[i]  = req.exec_page_address;
                            r.status      = ST_OK;
                        end
                    end
                end
            end
            MODE_DEL: begin
                for (int i = 0; i < N_ENTRIES; i++)
                    if (hit < 0 && hook_valid[i] && hook_addr[i] == req.target_address)
                        hit = i;
                if (hit >= 0) begin
                    hook_valid[hit] = 1'b0;
                    hook_addr[hit]  = '0;
                    hook_rw[hit]    = '0;
                    hook_exec[hit]  = '0;
                    r.status        = ST_OK;
                end
            end
            MODE_VIOL: begin
                // first live entry on the same 4 KiB page
                for (int i = 0; i < N_ENTRIES; i++)
                    if (hit < 0 && hook_valid[i] &&
                        hook_addr[i][ADDR_W-1:PAGE_SHIFT] ==
                        req.target_address[ADDR_W-1:PAGE_SHIFT])
                        hit = i;
                if (hit >= 0) begin
                    rw_fail = (req.did_read && !req.was_readable) ||
                              (req.did_write && !req.was_writable);
                    x_fail  = req.did_execute && !req.was_executable;
                    r.patched_entry_frame = hook_exec[hit][PAGE_W-1:PAGE_SHIFT];
                    if (rw_fail) begin
                        r.status     = ST_OK;
                        r.grant_read  = 1'b1;
                        r.grant_write = 1'b1;
                        r.new_frame   = hook_rw[hit][PAGE_W-1:PAGE_SHIFT];
                    end else if (x_fail) begin
                        r.status        = ST_OK;
                        r.grant_execute = 1'b1;
                        r.new_frame     = hook_exec[hit][PAGE_W-1:PAGE_SHIFT];
                    end else begin
                        r.status = ST_NOFAIL;
                    end
                end
            end
            default: ;                           // undefined mode: no-match, no change
        endcase
        return r;
    endfunction

    task automatic check_result(t_out_item want, t_out_item got);
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            err_count++;
        end
        if (got.grant_read !== want.grant_read) begin
            $error("grant_read: expected %0b, got %0b", want.grant_read, got.grant_read);
            err_count++;
        end
        if (got.grant_write !== want.grant_write) begin
            $error("grant_write: expected %0b, got %0b", want.grant_write, got.grant_write);
            err_count++;
        end
        if (got.grant_execute !== want.grant_execute) begin
            $error("grant_execute: expected %0b, got %0b",
                   want.grant_execute, got.grant_execute);
            err_count++;
        end
        if (got.new_frame !== want.new_frame) begin
            $error("new_frame: expected %h, got %h", want.new_frame, got.new_frame);
            err_count++;
        end
        if (got.patched_entry_frame !== want.patched_entry_frame) begin
            $error("patched_entry_frame: expected %h, got %h",
                   want.patched_entry_frame, got.patched_entry_frame);
            err_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // monitor: predicts on request acceptance, checks on result acceptance
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item predicted;
        t_out_item want;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                // predictor always runs so the table image tracks typed rows too
                predicted = resolve_request(in_if.data);
                pending_results.push_back(drv_typed ? drv_want : predicted);
                mode_seen[in_if.data.mode]++;
                reqs_accepted++;
            end
            if (out_if.valid && out_if.ready) begin
                if (pending_results.size() == 0) begin
                    $error("result transaction with no request outstanding");
                    err_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_result(want, out_if.data);
                end
                status_seen[out_if.data.status]++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // request sender: bursts of random length, random gaps in between
    // ------------------------------------------------------------------------
    initial begin : request_source
        int idx;
        int burst_left;
        int gap;
        in_if.valid <= 1'b0;
        in_if.data  <= '0;
        drv_typed   <= 1'b0;
        drv_want    <= '0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        idx = 0;
        while (idx < stim_q.size()) begin
            burst_left = $urandom_range(1, 10);
            while (burst_left > 0 && idx < stim_q.size()) begin
                in_if.valid <= 1'b1;
                in_if.data  <= stim_q[idx].req;
                drv_typed   <= stim_q[idx].typed;
                drv_want    <= stim_q[idx].want;
                @(posedge i_clk);
                while (!in_if.ready) @(posedge i_clk);
                idx++;
                burst_left--;
            end
            // one burst in five runs straight into the next
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 25);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        in_if.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // ------------------------------------------------------------------------
    // result receiver: open runs, stall runs and coin-flip runs, plus one long
    // holdoff that backs the block up into its request port
    // ------------------------------------------------------------------------
    initial begin : result_sink
        bit holdoff_done;
        int run_kind;
        int run_len;
        holdoff_done = 1'b0;
        out_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (!holdoff_done && reqs_accepted >= HOLDOFF_AFTER) begin
                holdoff_done = 1'b1;
                @(posedge i_clk);
                out_if.ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge i_clk);
            end
            run_kind = $urandom_range(0, 3);
            run_len  = (run_kind == 1) ? $urandom_range(1, 8) : $urandom_range(1, 40);
            repeat (run_len) begin
                @(posedge i_clk);
                case (run_kind)
                    1:       out_if.ready <= 1'b0;
                    2:       out_if.ready <= 1'($urandom_range(0, 1));
                    default: out_if.ready <= 1'b1;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // main: build stimulus, reset, wait for drain, report
    // ------------------------------------------------------------------------
    initial begin : main
        logic [11:0]       ofs;
        logic [5:0]        flags;
        logic [ADDR_W-1:0] addr;
        logic [1:0]        mode;
        int                pick;
        int                slot;
        int                n_rand;

        i_rst_n   <= 1'b0;
        stim_done  = 1'b0;
        err_count  = 0;
        cycle_count   = 0;
        reqs_accepted = 0;
        for (int i = 0; i < 4; i++) begin
            mode_seen[i]   = 0;
            status_seen[i] = 0;
        end
        for (int i = 0; i < N_ENTRIES; i++) begin
            hook_valid[i] = 1'b0;
            hook_addr[i]  = '0;
            hook_rw[i]    = '0;
            hook_exec[i]  = '0;
        end

        // address pool: random hooks, the first pairs share a page, plus the
        // two extremes near the end
        for (int k = 0; k < POOL_SIZE; k++) addr_pool[k] = rand64();
        for (int k = 0; k < 6; k++) begin
            ofs = 12'($urandom_range(1, 4095));
            addr_pool[2*k+1] = {addr_pool[2*k][63:12], addr_pool[2*k][11:0] ^ ofs};
        end
        addr_pool[POOL_SIZE-2] = '0;
        addr_pool[POOL_SIZE-1] = '1;

        // directed table; typed rows carry their result, the rest are predicted
        // empty table: address zero must not match a free slot
        stim_q.push_back('{mk_req(MODE_VIOL, '0, '0, '0, 6'b100_000), 1'b1,
                           mk_res(ST_NOMATCH, 3'b000, '0, '0)});
        stim_q.push_back('{mk_req(MODE_DEL, '0, '0, '0, 6'b000_000), 1'b1,
                           mk_res(ST_NOMATCH, 3'b000, '0, '0)});
        // undefined mode is ignored
        stim_q.push_back('{mk_req(MODE_UNDEF, '1, '1, '1, 6'b111_000), 1'b1,
                           mk_res(ST_NOMATCH, 3'b000, '0, '0)});
        // hook address zero with all-ones pages, then add it again (no change)
        stim_q.push_back('{mk_req(MODE_ADD, '0, '1, '1, 6'b000_000), 1'b1,
                           mk_res(ST_OK, 3'b000, '0, '0)});
        stim_q.push_back('{mk_req(MODE_ADD, '0, '0, '0, 6'b000_000), 1'b1,
                           mk_res(ST_OK, 3'b000, '0, '0)});
        // read failure elsewhere on page zero returns the all-ones frames
        stim_q.push_back('{mk_req(MODE_VIOL, 64'hFFF, '0, '0, 6'b100_000), 1'b1,
                           mk_res(ST_OK, 3'b110, '1, '1)});
        // hook the top address
        stim_q.push_back('{mk_req(MODE_ADD, '1, 52'h0_0000_0000_0ABC,
                                  52'hA_5A5A_5A5A_5000, 6'b000_000), 1'b1,
                           mk_res(ST_OK, 3'b000, '0, '0)});
        // execute-only failure, then a write failure while execute is permitted
        stim_q.push_back('{mk_req(MODE_VIOL, 64'hFFFF_FFFF_FFFF_F123, '0, '0, 6'b001_000),
                           1'b0, '0});
        stim_q.push_back('{mk_req(MODE_VIOL, 64'hFFFF_FFFF_FFFF_F123, '0, '0, 6'b011_101),
                           1'b0, '0});
        // entry found, every access permitted / no access at all
        stim_q.push_back('{mk_req(MODE_VIOL, 64'hFFFF_FFFF_FFFF_F000, '1, '1, 6'b111_111),
                           1'b0, '0});
        stim_q.push_back('{mk_req(MODE_VIOL, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0, 6'b000_000),
                           1'b0, '0});
        // delete needs an exact match
        stim_q.push_back('{mk_req(MODE_DEL, 64'hFFF, '0, '0, 6'b000_000), 1'b1,
                           mk_res(ST_NOMATCH, 3'b000, '0, '0)});
        stim_q.push_back('{mk_req(MODE_DEL, '0, '0, '0, 6'b000_000), 1'b1,
                           mk_res(ST_OK, 3'b000, '0, '0)});
        stim_q.push_back('{mk_req(MODE_VIOL, '0, '0, '0, 6'b010_000), 1'b1,
                           mk_res(ST_NOMATCH, 3'b000, '0, '0)});
        // fill the remaining slots, then one more add hits a full table
        for (int k = 0; k < N_ENTRIES - 1; k++)
            stim_q.push_back('{mk_req(MODE_ADD, addr_pool[k], rand52(), rand52(),
                                      6'b000_000), 1'b0, '0});
        stim_q.push_back('{mk_req(MODE_ADD, addr_pool[N_ENTRIES-1], '1, '1, 6'b000_000),
                           1'b1, mk_res(ST_FULL, 3'b000, '0, '0)});

        // random mix: mostly pool hits, some stray addresses, rare undefined mode
        n_rand = 0;
        while (n_rand < RANDOM_ITEMS) begin
            pick  = $urandom_range(0, 99);
            slot  = $urandom_range(0, POOL_SIZE - 1);
            flags = 6'($urandom);
            if (pick < 33) begin
                mode = MODE_ADD;
                // now and then a fresh hook replaces a pool address
                if ($urandom_range(0, 49) == 0)
                    addr_pool[$urandom_range(N_ENTRIES, POOL_SIZE - 3)] = rand64();
                addr = addr_pool[slot];
            end else if (pick < 55) begin
                mode = MODE_DEL;
                addr = ($urandom_range(0, 6) == 0) ? rand64() : addr_pool[slot];
            end else if (pick < 95) begin
                mode = MODE_VIOL;
                ofs  = 12'($urandom);
                addr = ($urandom_range(0, 9) == 0) ? rand64() : {addr_pool[slot][63:12], ofs};
            end else begin
                mode = MODE_UNDEF;
                addr = rand64();
            end
            stim_q.push_back('{mk_req(mode, addr, rand52(), rand52(), flags), 1'b0, '0});
            n_rand++;
        end

        // synchronous reset
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (stim_done);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Requests: %0d add, %0d delete, %0d violation, %0d undefined mode",
                 mode_seen[MODE_ADD], mode_seen[MODE_DEL], mode_seen[MODE_VIOL],
                 mode_seen[MODE_UNDEF]);
        $display("Results: %0d ok, %0d table full, %0d no match, %0d no failure",
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_NOMATCH],
                 status_seen[ST_NOFAIL]);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
